[rtl/ptw_pkg.sv]
package ptw_pkg;

   localparam int CmdDepth = 2;
   localparam int RspDepth = 2;

   localparam logic ActTranslate = 1'b0;
   localparam logic ActReadData  = 1'b1;

   localparam logic KindRead = 1'b0;
   localparam logic KindDone = 1'b1;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusFault = 2'd1;
   localparam logic [1:0] StatusPhase = 2'd2;

   localparam logic [1:0] CsrTableBase  = 2'd0;
   localparam logic [1:0] CsrRegionBase = 2'd1;
   localparam logic [1:0] CsrL2Bias     = 2'd2;

   localparam logic [1:0] DescFault    = 2'd0;
   localparam logic [1:0] DescTable    = 2'd1;
   localparam logic [1:0] DescSection  = 2'd2;
   localparam logic [1:0] DescReserved = 2'd3;
   localparam int SuperBit = 18;

   localparam logic [31:0] TableMask   = 32'hfffffc00;
   localparam logic [31:0] PageMask    = 32'hfffff000;
   localparam logic [31:0] SectionMask = 32'hfff00000;
   localparam logic [31:0] SuperMask   = 32'hff000000;

   typedef struct packed {
      logic        action;
      logic [31:0] virt_addr;
      logic [31:0] read_data;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_L1_READ = 3'd0,
      OP_L2_READ = 3'd1,
      OP_SECTION = 3'd2,
      OP_SUPER   = 3'd3,
      OP_PAGE    = 3'd4,
      OP_FAULT   = 3'd5,
      OP_PHASE   = 3'd6
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] va;
      logic [31:0] data;
   } cmd_type;

endpackage

[rtl/ptw_front.sv]
module ptw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptw_pkg::req_type  req_data,
   input  logic              cmd_full,
   output logic              cmd_push,
   output ptw_pkg::cmd_type  cmd_data
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_L1   = 3'b010,
      PH_L2   = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] saved_virt_ff, saved_virt_in;
   logic [1:0]  desc_type;

   assign cmd_push  = push && !cmd_full;
   assign desc_type = req_data.read_data[1:0];

   always_comb begin
      phase_in      = phase_ff;
      saved_virt_in = saved_virt_ff;
      cmd_data.op   = ptw_pkg::OP_PHASE;
      cmd_data.va   = saved_virt_ff;
      cmd_data.data = req_data.read_data;
      if (req_data.action == ptw_pkg::ActTranslate) begin
         if (phase_ff != PH_L1 && phase_ff != PH_L2) begin
            cmd_data.op   = ptw_pkg::OP_L1_READ;
            cmd_data.va   = req_data.virt_addr;
            saved_virt_in = req_data.virt_addr;
            phase_in      = PH_L1;
         end
      end else begin
         case (phase_ff)
            PH_L1: begin
               phase_in = PH_IDLE;
               case (desc_type)
                  ptw_pkg::DescTable: begin
                     cmd_data.op = ptw_pkg::OP_L2_READ;
                     phase_in    = PH_L2;
                  end
                  ptw_pkg::DescSection: begin
                     cmd_data.op = req_data.read_data[ptw_pkg::SuperBit] ?
                                   ptw_pkg::OP_SUPER : ptw_pkg::OP_SECTION;
                  end
                  default: begin
                     cmd_data.op = ptw_pkg::OP_FAULT;
                  end
               endcase
            end
            PH_L2: begin
               cmd_data.op = ptw_pkg::OP_PAGE;
               phase_in    = PH_IDLE;
            end
            default: begin
               cmd_data.op = ptw_pkg::OP_PHASE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         saved_virt_ff <= '0;
      end else if (cmd_push) begin
         phase_ff      <= phase_in;
         saved_virt_ff <= saved_virt_in;
      end
   end

   a_l1_enters_walk: assert property (@(posedge clock) disable iff (reset)
      cmd_push && cmd_data.op == ptw_pkg::OP_L1_READ |=> phase_ff == PH_L1)
      else $error("first-level read issued without entering the walk");

   a_phase_error_keeps_state: assert property (@(posedge clock) disable iff (reset)
      cmd_push && cmd_data.op == ptw_pkg::OP_PHASE
      |=> $stable(phase_ff) && $stable(saved_virt_ff))
      else $error("out-of-phase request changed the walk state");

   a_l2_only_from_l1: assert property (@(posedge clock) disable iff (reset)
      cmd_push && cmd_data.op == ptw_pkg::OP_L2_READ |-> phase_ff == PH_L1)
      else $error("second-level read issued outside the first-level phase");

endmodule

[rtl/ptw_cmd_queue.sv]
module ptw_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptw_pkg::cmd_type  push_data,
   output logic              full,
   input  logic              pop,
   output ptw_pkg::cmd_type  pop_data,
   output logic              empty
);

   localparam int Depth = ptw_pkg::CmdDepth;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   ptw_pkg::cmd_type mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("command queue count exceeds its depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("command queue lost a request");

endmodule

[rtl/ptw_back.sv]
module ptw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   input  logic              cmd_empty,
   input  ptw_pkg::cmd_type  cmd_data,
   output logic              cmd_pop,
   input  logic              pop,
   output logic              empty,
   output ptw_pkg::rsp_type  rsp_data
);

   localparam int Depth = ptw_pkg::RspDepth;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   logic [31:0]      table_base_ff, region_base_ff, l2_bias_ff;
   ptw_pkg::rsp_type mem_ff [Depth];
   ptw_pkg::rsp_type result;
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_pop;
   logic [31:0]      rel_va;

   assign empty    = (count_ff == '0);
   assign do_pop   = pop && !empty;
   assign cmd_pop  = !cmd_empty && (count_ff != CntW'(Depth) || do_pop);
   assign rsp_data = mem_ff[rd_ptr_ff];
   assign rel_va   = cmd_data.va - region_base_ff;

   always_comb begin
      result.kind    = ptw_pkg::KindDone;
      result.address = '0;
      result.status  = ptw_pkg::StatusOk;
      case (cmd_data.op)
         ptw_pkg::OP_L1_READ: begin
            result.kind    = ptw_pkg::KindRead;
            result.address = table_base_ff + {18'd0, rel_va[31:20], 2'b00};
         end
         ptw_pkg::OP_L2_READ: begin
            result.kind    = ptw_pkg::KindRead;
            result.address = (cmd_data.data & ptw_pkg::TableMask) + l2_bias_ff
                             + {22'd0, cmd_data.va[19:12], 2'b00};
         end
         ptw_pkg::OP_SECTION: begin
            result.address = (cmd_data.data & ptw_pkg::SectionMask)
                             | (cmd_data.va & ~ptw_pkg::SectionMask);
         end
         ptw_pkg::OP_SUPER: begin
            result.address = (cmd_data.data & ptw_pkg::SuperMask)
                             | (cmd_data.va & ~ptw_pkg::SuperMask);
         end
         ptw_pkg::OP_PAGE: begin
            result.address = (cmd_data.data & ptw_pkg::PageMask)
                             | (cmd_data.va & ~ptw_pkg::PageMask);
         end
         ptw_pkg::OP_FAULT: begin
            result.status = ptw_pkg::StatusFault;
         end
         default: begin
            result.status = ptw_pkg::StatusPhase;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff  <= '0;
         region_base_ff <= '0;
         l2_bias_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ptw_pkg::CsrTableBase:  table_base_ff  <= csr_wdata;
            ptw_pkg::CsrRegionBase: region_base_ff <= csr_wdata;
            ptw_pkg::CsrL2Bias:     l2_bias_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd_pop && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !cmd_pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         mem_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd_pop) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
      end
   end

   a_rsp_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("result queue count exceeds its depth");

endmodule

[rtl/two_level_page_table_walker.sv]
// Two-level page table walker with queue-style ports on both sides.
// A request (push/full) is either a translate request or a memory read data
// return. Each request produces exactly one response (empty/pop): a memory
// read to perform, a finished translation, a translation fault, or an
// out-of-phase error. The caller performs each read and pushes the data back.
// A request is taken when push is high and full is low; the response passes
// through the command queue and then the response queue to the result ports,
// where it is held until popped. One request per cycle is sustained while
// responses are popped: the front end updates the walk phase in the cycle of
// acceptance, and the back end forms addresses one command per cycle into a
// two-entry response queue.
// When pop stays low, the response queue and then the two-entry command
// queue fill, and full rises; nothing is dropped.
// Registers are written through csr_valid/csr_ready (always ready): index 0
// table base, 1 region base, 2 second-level bias. The user writes them
// only while the walker is idle; the block does not enforce it. Synchronous
// reset clears the queues and all registers and returns the walk to idle.
module two_level_page_table_walker (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptw_pkg::req_type  req_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output ptw_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   logic             cmd_push, cmd_pop, cmd_empty;
   ptw_pkg::cmd_type cmd_in, cmd_out;

   assign csr_ready = 1'b1;

   ptw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .cmd_full (full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in)
   );

   ptw_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   ptw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule

[verif/two_level_page_table_walker_tb.sv]
`timescale 1ns / 100ps

module two_level_page_table_walker_tb;

   localparam int HalfPeriod   = 6;
   localparam int ResetCycles  = 8;
   localparam int QuietLimit   = 2000;
   localparam int SettleCycles = 20;
   localparam int HoldCycles   = 150;
   localparam int MaxReports   = 10;

   typedef enum logic [2:0] {
      WALK_IDLE = 3'b001,
      WALK_L1   = 3'b010,
      WALK_L2   = 3'b100
   } walk_phase_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             push;
   ptw_pkg::req_type req_data;
   logic             full;
   logic             empty;
   logic             pop;
   ptw_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [1:0]       csr_index;
   logic [31:0]      csr_wdata;

   logic [31:0]    cfg_table_base;
   logic [31:0]    cfg_region_base;
   logic [31:0]    cfg_l2_bias;
   walk_phase_type walk_phase;
   logic [31:0]    walk_va;

   ptw_pkg::rsp_type results_due[$];
   ptw_pkg::rsp_type expected_rsp;
   int      rsp_failures = 0;
   int      quiet_cycles = 0;
   int      pop_wait = 0;
   int      pop_hold = 0;
   bit      push_steady = 1'b0;
   bit      pop_steady = 1'b0;

   two_level_page_table_walker DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HalfPeriod) clock = ~clock;

   function automatic ptw_pkg::rsp_type walk_predict(input ptw_pkg::req_type r);
      ptw_pkg::rsp_type res;
      logic [31:0] index;
      logic [31:0] d;
      res.kind = ptw_pkg::KindDone;
      res.address = '0;
      res.status = ptw_pkg::StatusPhase;
      d = r.read_data;
      if (r.action == ptw_pkg::ActTranslate) begin
         if (walk_phase != WALK_L1 && walk_phase != WALK_L2) begin
            walk_va = r.virt_addr;
            index = (r.virt_addr - cfg_region_base) >> 20;
            walk_phase = WALK_L1;
            res.kind = ptw_pkg::KindRead;
            res.address = cfg_table_base + (index << 2);
            res.status = ptw_pkg::StatusOk;
         end
      end else if (walk_phase == WALK_L2) begin
         walk_phase = WALK_IDLE;
         res.address = (d & ptw_pkg::PageMask) | {20'b0, walk_va[11:0]};
         res.status = ptw_pkg::StatusOk;
      end else if (walk_phase == WALK_L1) begin
         case (d[1:0])
            ptw_pkg::DescSection: begin
               walk_phase = WALK_IDLE;
               res.status = ptw_pkg::StatusOk;
               if (d[ptw_pkg::SuperBit]) begin
                  res.address = (d & ptw_pkg::SuperMask) | {8'b0, walk_va[23:0]};
               end else begin
                  res.address = (d & ptw_pkg::SectionMask) | {12'b0, walk_va[19:0]};
               end
            end
            ptw_pkg::DescTable: begin
               walk_phase = WALK_L2;
               res.kind = ptw_pkg::KindRead;
               res.status = ptw_pkg::StatusOk;
               res.address = (d & ptw_pkg::TableMask) + cfg_l2_bias
                             + {22'b0, walk_va[19:12], 2'b00};
            end
            default: begin
               walk_phase = WALK_IDLE;
               res.status = ptw_pkg::StatusFault;
            end
         endcase
      end
      return res;
   endfunction

   function automatic logic [31:0] random_l1_descriptor();
      logic [31:0] d;
      d = $urandom;
      case ($urandom_range(0, 9))
         0: d = '0;
         1: d[1:0] = ptw_pkg::DescFault;
         2: d[1:0] = ptw_pkg::DescReserved;
         3, 4: begin
            d[1:0] = ptw_pkg::DescSection;
            d[ptw_pkg::SuperBit] = 1'b0;
         end
         5, 6: begin
            d[1:0] = ptw_pkg::DescSection;
            d[ptw_pkg::SuperBit] = 1'b1;
         end
         default: d[1:0] = ptw_pkg::DescTable;
      endcase
      return d;
   endfunction

   task automatic push_walk_request(input logic action, input logic [31:0] va,
                                    input logic [31:0] data);
      ptw_pkg::req_type r;
      int gap;
      r.action = action;
      r.virt_addr = va;
      r.read_data = data;
      gap = push_steady ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      results_due.push_back(walk_predict(r));
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         ptw_pkg::CsrTableBase:  cfg_table_base = value;
         ptw_pkg::CsrRegionBase: cfg_region_base = value;
         ptw_pkg::CsrL2Bias:     cfg_l2_bias = value;
         default: ;
      endcase
   endtask

   task automatic configure_walker(input logic [31:0] table_base,
                                   input logic [31:0] region_base,
                                   input logic [31:0] l2_bias);
      write_register(ptw_pkg::CsrTableBase, table_base);
      write_register(ptw_pkg::CsrRegionBase, region_base);
      write_register(ptw_pkg::CsrL2Bias, l2_bias);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      push <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic finish_walk();
      while (walk_phase != WALK_IDLE) begin
         push_walk_request(ptw_pkg::ActReadData, $urandom,
                           ($urandom & ~32'h3) | {30'b0, ptw_pkg::DescSection});
      end
   endtask

   // Sends one complete walk and returns the number of requests it took.
   task automatic send_walk(output int count);
      push_walk_request(ptw_pkg::ActTranslate, $urandom, $urandom);
      push_walk_request(ptw_pkg::ActReadData, $urandom, random_l1_descriptor());
      count = 2;
      if (walk_phase == WALK_L2) begin
         push_walk_request(ptw_pkg::ActReadData, $urandom, $urandom);
         count = 3;
      end
   endtask

   task automatic test_directed();
      configure_walker(32'h0, 32'h0, 32'h0);
      push_walk_request(ptw_pkg::ActReadData, 32'h0, 32'hffffffff);
      push_walk_request(ptw_pkg::ActTranslate, 32'h00000000, 32'h0);
      push_walk_request(ptw_pkg::ActTranslate, 32'hffffffff, 32'h0);
      push_walk_request(ptw_pkg::ActReadData, 32'h0, 32'h00000000);
      push_walk_request(ptw_pkg::ActTranslate, 32'hffffffff, 32'h0);
      push_walk_request(ptw_pkg::ActReadData, 32'h0, 32'hfffffff3);
      push_walk_request(ptw_pkg::ActTranslate, 32'h12345678, 32'h0);
      push_walk_request(ptw_pkg::ActReadData, 32'h0, 32'h00000004);
      push_walk_request(ptw_pkg::ActTranslate, 32'hfedcba98, 32'h0);
      push_walk_request(ptw_pkg::ActReadData, 32'h0, 32'habc00002);
      push_walk_request(ptw_pkg::ActTranslate, 32'h13579bdf, 32'h0);
      push_walk_request(ptw_pkg::ActReadData, 32'h0, 32'hab040002);
      push_walk_request(ptw_pkg::ActTranslate, 32'h000ff000, 32'h0);
      push_walk_request(ptw_pkg::ActReadData, 32'h0, 32'h00000001);
      push_walk_request(ptw_pkg::ActTranslate, 32'h55555555, 32'h0);
      push_walk_request(ptw_pkg::ActReadData, 32'h0, 32'hfffff003);
      push_walk_request(ptw_pkg::ActTranslate, 32'h00000abc, 32'h0);
      push_walk_request(ptw_pkg::ActReadData, 32'h0, 32'h000003fd);
      push_walk_request(ptw_pkg::ActReadData, 32'hffffffff, 32'h00000000);
      push_walk_request(ptw_pkg::ActReadData, 32'h0, 32'h00000002);
      push_walk_request(ptw_pkg::ActTranslate, 32'hffffffff, 32'hffffffff);
      push_walk_request(ptw_pkg::ActReadData, 32'hffffffff, 32'hfffffffd);
      push_walk_request(ptw_pkg::ActReadData, 32'hffffffff, 32'hffffffff);
      wait_for_results();
   endtask

   task automatic test_random_walks(input int target);
      int sent;
      int count;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 63) == 0) begin
            push_steady = ($urandom_range(0, 2) == 0);
            pop_steady = ($urandom_range(0, 2) == 0);
         end
         if ($urandom_range(0, 7) == 0) begin
            push_walk_request(1'($urandom_range(0, 1)), $urandom, $urandom);
         end else begin
            send_walk(count);
            sent += count;
         end
      end
      finish_walk();
      push_steady = 1'b0;
      pop_steady = 1'b0;
      wait_for_results();
   endtask

   task automatic test_extreme_settings();
      configure_walker(32'hffffffff, 32'hffffffff, 32'hffffffff);
      test_random_walks(150);
      configure_walker(32'h00000000, 32'hffffffff, 32'h80000000);
      test_random_walks(100);
   endtask

   task automatic test_random_settings();
      repeat (4) begin
         configure_walker($urandom, $urandom, $urandom);
         test_random_walks(150);
      end
   endtask

   task automatic test_backpressure();
      int count;
      configure_walker($urandom, $urandom, $urandom);
      pop_hold = HoldCycles;
      push_steady = 1'b1;
      repeat (16) send_walk(count);
      push_steady = 1'b0;
      finish_walk();
      wait_for_results();
   endtask

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("two_level_page_table_walker: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (results_due.size() == 0) begin
            rsp_failures++;
            if (rsp_failures <= MaxReports) begin
               $display("unexpected response: kind %0d address %h status %0d",
                        rsp_data.kind, rsp_data.address, rsp_data.status);
            end
         end else begin
            expected_rsp = results_due.pop_front();
            if (rsp_data.kind !== expected_rsp.kind
                || rsp_data.address !== expected_rsp.address
                || rsp_data.status !== expected_rsp.status) begin
               rsp_failures++;
               if (rsp_failures <= MaxReports) begin
                  $display("response check failed: expected kind %0d address %h status %0d,",
                           expected_rsp.kind, expected_rsp.address, expected_rsp.status);
                  $display("   got kind %0d address %h status %0d",
                           rsp_data.kind, rsp_data.address, rsp_data.status);
               end
            end
         end
         pop_wait = pop_steady ? 0 : $urandom_range(0, 9);
      end
   end

   initial begin
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            pop <= 1'b0;
         end else if (pop_hold > 0) begin
            pop_hold--;
            pop <= 1'b0;
         end else if (pop_wait > 0) begin
            pop_wait--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_table_base = '0;
      cfg_region_base = '0;
      cfg_l2_bias = '0;
      walk_phase = WALK_IDLE;
      walk_va = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_extreme_settings();
      test_random_settings();
      test_backpressure();

      wait_for_results();
      repeat (SettleCycles) @(posedge clock);
      if (rsp_failures == 0 && results_due.size() == 0) begin
         $display("two_level_page_table_walker: match");
      end else begin
         $display("two_level_page_table_walker: mismatch");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/ptw_pkg.sv
rtl/ptw_front.sv
rtl/ptw_cmd_queue.sv
rtl/ptw_back.sv
rtl/two_level_page_table_walker.sv
verif/two_level_page_table_walker_tb.sv
